/* design/assert_macros.svh */
// Assertion helper macros shared by the RTL files.
// Each macro expects clk and the active-low reset rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is held
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked while reset is held
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/ehpf_pkg.sv */
// Types and constants for the Ethernet/IPv4/L4 header parser and filter.
// No dependencies.
package ehpf_pkg;

  // Verdict codes carried on the result status field
  typedef enum logic [3:0] {
    ST_TCP_OK     = 4'd0,
    ST_UDP_OK     = 4'd1,
    ST_NOT_IPV4   = 4'd2,
    ST_SRC_IP     = 4'd3,
    ST_DST_IP     = 4'd4,
    ST_FRAGMENT   = 4'd5,
    ST_OTHER_PROTO = 4'd6,
    ST_SPORT      = 4'd7,
    ST_DPORT      = 4'd8,
    ST_TRUNCATED  = 4'd9,
    ST_BAD_IHL    = 4'd10
  } status_t;

  // Configuration register indexes (word address)
  typedef enum logic [2:0] {
    REG_SRC_IP_MATCH  = 3'd0,
    REG_SRC_IP_ON     = 3'd1,
    REG_DST_IP_MATCH  = 3'd2,
    REG_DST_IP_ON     = 3'd3,
    REG_SRC_PORT      = 3'd4,
    REG_DST_PORT      = 3'd5
  } reg_idx_t;

  localparam int unsigned PADDR_W = 5;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [3:0]  MIN_IHL        = 4'd5;
  localparam logic [6:0]  ETH_HDR_LEN    = 7'd14;

  // Byte positions within the frame
  localparam logic [15:0] POS_DMAC_END   = 16'd6;
  localparam logic [15:0] POS_SMAC_END   = 16'd12;
  localparam logic [15:0] POS_ETYPE_END  = 16'd14;
  localparam logic [15:0] POS_ETYPE_LO   = 16'd13;
  localparam logic [15:0] POS_VER_IHL    = 16'd14;
  localparam logic [15:0] POS_TLEN_HI    = 16'd16;
  localparam logic [15:0] POS_TLEN_LO    = 16'd17;
  localparam logic [15:0] POS_FRAG_HI    = 16'd20;
  localparam logic [15:0] POS_FRAG_LO    = 16'd21;
  localparam logic [15:0] POS_TTL        = 16'd22;
  localparam logic [15:0] POS_PROTO      = 16'd23;
  localparam logic [15:0] POS_ADDR_START = 16'd26;
  localparam logic [15:0] POS_SRC_IP_END = 16'd29;
  localparam logic [15:0] POS_DST_IP_END = 16'd33;
  localparam logic [15:0] POS_ADDR_END   = 16'd34;
  localparam logic [15:0] POS_MAX        = 16'hFFFF;

  // Offsets from the start of the transport header
  localparam logic [15:0] OFF_PORTS_END  = 16'd4;
  localparam logic [15:0] OFF_SPORT_LO   = 16'd1;
  localparam logic [15:0] OFF_DPORT_LO   = 16'd3;
  localparam logic [15:0] OFF_UDP_END    = 16'd6;
  localparam logic [15:0] OFF_UDP_LEN_LO = 16'd5;
  localparam logic [15:0] OFF_TCP_FLAGS  = 16'd13;

endpackage

/* design/eth_ipv4_l4_header_parse_filter.sv */
// Ethernet/IPv4/L4 header parser and filter, one frame byte per transfer.
// The result is registered and appears in the cycle after the last byte's transfer.
// Throughput: one byte per cycle unless a held result stalls in_ready; set by
// the single byte-decode stage loading capture and output registers together.
// Reset (rst_n, synchronous, active low) clears configuration and frame state.
// Depends on ehpf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module eth_ipv4_l4_header_parse_filter
  import ehpf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // byte stream in
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_byte,
  // result out
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_status,
  output logic [47:0]         out_dst_mac,
  output logic [47:0]         out_src_mac,
  output logic [15:0]         out_ethertype,
  output logic [7:0]          out_ip_version_ihl,
  output logic [15:0]         out_ip_total_length,
  output logic [12:0]         out_fragment_offset,
  output logic [7:0]          out_time_to_live,
  output logic [7:0]          out_proto_number,
  output logic [63:0]         out_ip_address_pair,
  output logic [31:0]         out_port_pair,
  output logic [15:0]         out_transport_info,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // configuration registers
  logic [31:0] src_ip_match_r;
  logic        src_ip_on_r;
  logic [31:0] dst_ip_match_r;
  logic        dst_ip_on_r;
  logic [15:0] src_port_r;
  logic [15:0] dst_port_r;

  // frame state
  logic [15:0] pos_r,       pos_nxt;
  logic        done_r,      done_nxt;
  status_t     status_r,    status_nxt;
  logic [47:0] dmac_r,      dmac_nxt;
  logic [47:0] smac_r,      smac_nxt;
  logic [15:0] etype_r,     etype_nxt;
  logic [7:0]  ipfirst_r,   ipfirst_nxt;
  logic [15:0] tlen_r,      tlen_nxt;
  logic [12:0] frag_r,      frag_nxt;
  logic [7:0]  ttl_r,       ttl_nxt;
  logic [7:0]  proto_r,     proto_nxt;
  logic [63:0] addr_r,      addr_nxt;
  logic [31:0] ports_r,     ports_nxt;
  logic [15:0] l4info_r,    l4info_nxt;

  // output register
  logic        out_valid_r;
  status_t     o_status_r;
  logic [47:0] o_dmac_r, o_smac_r;
  logic [15:0] o_etype_r, o_tlen_r, o_l4info_r;
  logic [7:0]  o_ipfirst_r, o_ttl_r, o_proto_r;
  logic [12:0] o_frag_r;
  logic [63:0] o_addr_r;
  logic [31:0] o_ports_r;

  logic        in_xfer;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;
  logic [6:0]  l4_start;
  logic [15:0] l4_off;

  // zero octets of the match value act as wildcards
  function automatic logic dst_ok(input logic [31:0] want, input logic [31:0] got);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (want[8*k +: 8] != 8'd0 && want[8*k +: 8] != got[8*k +: 8])
        ok = 1'b0;
    end
    return ok;
  endfunction

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_ip_match_r <= '0;
      src_ip_on_r    <= 1'b0;
      dst_ip_match_r <= '0;
      dst_ip_on_r    <= 1'b0;
      src_port_r     <= '0;
      dst_port_r     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SRC_IP_MATCH: src_ip_match_r <= pwdata;
        REG_SRC_IP_ON:    src_ip_on_r    <= pwdata[0];
        REG_DST_IP_MATCH: dst_ip_match_r <= pwdata;
        REG_DST_IP_ON:    dst_ip_on_r    <= pwdata[0];
        REG_SRC_PORT:     src_port_r     <= pwdata[15:0];
        REG_DST_PORT:     dst_port_r     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    unique case (cfg_idx)
      REG_SRC_IP_MATCH: prdata = src_ip_match_r;
      REG_SRC_IP_ON:    prdata = {31'd0, src_ip_on_r};
      REG_DST_IP_MATCH: prdata = dst_ip_match_r;
      REG_DST_IP_ON:    prdata = {31'd0, dst_ip_on_r};
      REG_SRC_PORT:     prdata = {16'd0, src_port_r};
      REG_DST_PORT:     prdata = {16'd0, dst_port_r};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Transport header position from IHL
  assign l4_start = ETH_HDR_LEN + {1'b0, ipfirst_r[3:0], 2'b00};
  assign l4_off   = pos_r - {9'd0, l4_start};

  // Byte decode: capture by position and apply filters in order
  always_comb begin
    done_nxt    = done_r;
    status_nxt  = status_r;
    dmac_nxt    = dmac_r;
    smac_nxt    = smac_r;
    etype_nxt   = etype_r;
    ipfirst_nxt = ipfirst_r;
    tlen_nxt    = tlen_r;
    frag_nxt    = frag_r;
    ttl_nxt     = ttl_r;
    proto_nxt   = proto_r;
    addr_nxt    = addr_r;
    ports_nxt   = ports_r;
    l4info_nxt  = l4info_r;

    if (!done_r) begin
      if (pos_r < POS_DMAC_END) begin
        dmac_nxt = {dmac_r[39:0], in_data_byte};
      end else if (pos_r < POS_SMAC_END) begin
        smac_nxt = {smac_r[39:0], in_data_byte};
      end else if (pos_r < POS_ETYPE_END) begin
        etype_nxt = {etype_r[7:0], in_data_byte};
        if (pos_r == POS_ETYPE_LO && etype_nxt != ETHERTYPE_IPV4) begin
          done_nxt   = 1'b1;
          status_nxt = ST_NOT_IPV4;
        end
      end else if (pos_r == POS_VER_IHL) begin
        ipfirst_nxt = in_data_byte;
      end else if (pos_r == POS_TLEN_HI || pos_r == POS_TLEN_LO) begin
        tlen_nxt = {tlen_r[7:0], in_data_byte};
      end else if (pos_r == POS_FRAG_HI || pos_r == POS_FRAG_LO) begin
        frag_nxt = {frag_r[4:0], in_data_byte};
      end else if (pos_r == POS_TTL) begin
        ttl_nxt = in_data_byte;
      end else if (pos_r == POS_PROTO) begin
        proto_nxt = in_data_byte;
      end else if (pos_r >= POS_ADDR_START && pos_r < POS_ADDR_END) begin
        addr_nxt = {addr_r[55:0], in_data_byte};
        if (pos_r == POS_SRC_IP_END) begin
          if (src_ip_on_r && addr_nxt[31:0] != src_ip_match_r) begin
            done_nxt   = 1'b1;
            status_nxt = ST_SRC_IP;
          end
        end else if (pos_r == POS_DST_IP_END) begin
          done_nxt = 1'b1;
          if (dst_ip_on_r && !dst_ok(dst_ip_match_r, addr_nxt[31:0]))
            status_nxt = ST_DST_IP;
          else if (frag_r != 13'd0)
            status_nxt = ST_FRAGMENT;
          else if (proto_r != PROTO_TCP && proto_r != PROTO_UDP)
            status_nxt = ST_OTHER_PROTO;
          else if (ipfirst_r[3:0] < MIN_IHL)
            status_nxt = ST_BAD_IHL;
          else
            done_nxt = 1'b0;
        end
      end else if (pos_r >= POS_ADDR_END && pos_r >= {9'd0, l4_start}) begin
        // transport header: ports, then UDP length or TCP flags
        if (l4_off < OFF_PORTS_END) begin
          ports_nxt = {ports_r[23:0], in_data_byte};
          if (l4_off == OFF_SPORT_LO && src_port_r != 16'd0 &&
              ports_nxt[15:0] != src_port_r) begin
            done_nxt   = 1'b1;
            status_nxt = ST_SPORT;
          end else if (l4_off == OFF_DPORT_LO && dst_port_r != 16'd0 &&
                       ports_nxt[15:0] != dst_port_r) begin
            done_nxt   = 1'b1;
            status_nxt = ST_DPORT;
          end
        end else if (proto_r == PROTO_UDP) begin
          if (l4_off < OFF_UDP_END) begin
            l4info_nxt = {l4info_r[7:0], in_data_byte};
            if (l4_off == OFF_UDP_LEN_LO) begin
              done_nxt   = 1'b1;
              status_nxt = ST_UDP_OK;
            end
          end
        end else if (l4_off == OFF_TCP_FLAGS) begin
          l4info_nxt = {14'd0, in_data_byte[1:0]};
          done_nxt   = 1'b1;
          status_nxt = ST_TCP_OK;
        end
      end
    end

    // saturating byte counter
    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 16'd1;
  end

  // ---------------------------------------------------------------------------
  // Frame state: advance per transfer, clear after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (in_xfer && in_last_byte)) begin
      pos_r     <= '0;
      done_r    <= 1'b0;
      status_r  <= ST_TCP_OK;
      dmac_r    <= '0;
      smac_r    <= '0;
      etype_r   <= '0;
      ipfirst_r <= '0;
      tlen_r    <= '0;
      frag_r    <= '0;
      ttl_r     <= '0;
      proto_r   <= '0;
      addr_r    <= '0;
      ports_r   <= '0;
      l4info_r  <= '0;
    end else if (in_xfer) begin
      pos_r     <= pos_nxt;
      done_r    <= done_nxt;
      status_r  <= status_nxt;
      dmac_r    <= dmac_nxt;
      smac_r    <= smac_nxt;
      etype_r   <= etype_nxt;
      ipfirst_r <= ipfirst_nxt;
      tlen_r    <= tlen_nxt;
      frag_r    <= frag_nxt;
      ttl_r     <= ttl_nxt;
      proto_r   <= proto_nxt;
      addr_r    <= addr_nxt;
      ports_r   <= ports_nxt;
      l4info_r  <= l4info_nxt;
    end
  end

  // Output register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload, loaded with the last byte's decode
  always_ff @(posedge clk) begin
    if (in_xfer && in_last_byte) begin
      o_status_r  <= done_nxt ? status_nxt : ST_TRUNCATED;
      o_dmac_r    <= dmac_nxt;
      o_smac_r    <= smac_nxt;
      o_etype_r   <= etype_nxt;
      o_ipfirst_r <= ipfirst_nxt;
      o_tlen_r    <= tlen_nxt;
      o_frag_r    <= frag_nxt;
      o_ttl_r     <= ttl_nxt;
      o_proto_r   <= proto_nxt;
      o_addr_r    <= addr_nxt;
      o_ports_r   <= ports_nxt;
      o_l4info_r  <= l4info_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = o_status_r;
  assign out_dst_mac         = o_dmac_r;
  assign out_src_mac         = o_smac_r;
  assign out_ethertype       = o_etype_r;
  assign out_ip_version_ihl  = o_ipfirst_r;
  assign out_ip_total_length = o_tlen_r;
  assign out_fragment_offset = o_frag_r;
  assign out_time_to_live    = o_ttl_r;
  assign out_proto_number    = o_proto_r;
  assign out_ip_address_pair = o_addr_r;
  assign out_port_pair       = o_ports_r;
  assign out_transport_info  = o_l4info_r;

  // ---------------------------------------------------------------------------
  // Assertions
  `ASSERT_IMPLIES(a_stall_blocks_input, out_valid_r && !out_ready, !in_ready)
  `ASSERT_NEXT(a_last_gives_result, in_xfer && in_last_byte, out_valid_r)
  `ASSERT_NEXT(a_last_clears_frame, in_xfer && in_last_byte, pos_r == 16'd0 && !done_r)
  `ASSERT_IMPLIES(a_status_in_range, out_valid_r, o_status_r <= ST_BAD_IHL)

endmodule

/* verif/tb_eth_ipv4_l4_header_parse_filter.sv */
// Self-checking testbench for eth_ipv4_l4_header_parse_filter: frames in, one
// verdict per frame out, each checked against a local header predictor.
// Depends on ehpf_pkg and the RTL top level; reads no files.
module tb_eth_ipv4_l4_header_parse_filter
  import ehpf_pkg::*;
;

  // Everything one frame verdict carries
  typedef struct {
    status_t     status;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ethertype;
    logic [7:0]  ver_ihl;
    logic [15:0] total_length;
    logic [12:0] frag_offset;
    logic [7:0]  ttl;
    logic [7:0]  protocol;
    logic [63:0] addr_pair;
    logic [31:0] port_pair;
    logic [15:0] transport;
  } header_result_t;

  // Header parser/filter predictor plus the queue of verdicts still owed
  class header_scoreboard;
    logic [31:0]    src_ip_want;
    logic           src_ip_on;
    logic [31:0]    dst_ip_want;
    logic           dst_ip_on;
    logic [15:0]    sport_want;
    logic [15:0]    dport_want;
    logic [15:0]    frame_pos;
    bit             verdict_set;
    status_t        verdict;
    header_result_t cap;
    header_result_t verdicts_owed[$];
    int             errors;
    int             checked;
    int             seen[16];

    function void clear_frame();
      frame_pos   = '0;
      verdict_set = 1'b0;
      verdict     = ST_TCP_OK;
      cap         = '{status: ST_TCP_OK, default: '0};
    endfunction

    function void reset_model();
      src_ip_want = '0;
      src_ip_on   = 1'b0;
      dst_ip_want = '0;
      dst_ip_on   = 1'b0;
      sport_want  = '0;
      dport_want  = '0;
      clear_frame();
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_SRC_IP_MATCH: src_ip_want = v;
        REG_SRC_IP_ON:    src_ip_on   = v[0];
        REG_DST_IP_MATCH: dst_ip_want = v;
        REG_DST_IP_ON:    dst_ip_on   = v[0];
        REG_SRC_PORT:     sport_want  = v[15:0];
        REG_DST_PORT:     dport_want  = v[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return verdicts_owed.size();
    endfunction

    function void conclude(status_t st);
      verdict     = st;
      verdict_set = 1'b1;
    endfunction

    // Zero octets in the destination pattern are wildcards
    function bit dst_hit(logic [31:0] addr);
      for (int k = 0; k < 4; k++)
        if (dst_ip_want[8*k +: 8] != 8'd0 && dst_ip_want[8*k +: 8] != addr[8*k +: 8])
          return 1'b0;
      return 1'b1;
    endfunction

    // One byte at position p, only while no verdict has been reached
    function void absorb(int p, logic [7:0] b);
      int l4;
      int off;
      if (p < POS_DMAC_END) begin
        cap.dst_mac = {cap.dst_mac[39:0], b};
      end else if (p < POS_SMAC_END) begin
        cap.src_mac = {cap.src_mac[39:0], b};
      end else if (p < POS_ETYPE_END) begin
        cap.ethertype = {cap.ethertype[7:0], b};
        if (p == POS_ETYPE_LO && cap.ethertype != ETHERTYPE_IPV4)
          conclude(ST_NOT_IPV4);
      end else if (p == POS_VER_IHL) begin
        cap.ver_ihl = b;
      end else if (p == POS_TLEN_HI || p == POS_TLEN_LO) begin
        cap.total_length = {cap.total_length[7:0], b};
      end else if (p == POS_FRAG_HI || p == POS_FRAG_LO) begin
        cap.frag_offset = {cap.frag_offset[4:0], b};
      end else if (p == POS_TTL) begin
        cap.ttl = b;
      end else if (p == POS_PROTO) begin
        cap.protocol = b;
      end else if (p >= POS_ADDR_START && p < POS_ADDR_END) begin
        cap.addr_pair = {cap.addr_pair[55:0], b};
        if (p == POS_SRC_IP_END) begin
          if (src_ip_on && cap.addr_pair[31:0] != src_ip_want)
            conclude(ST_SRC_IP);
        end else if (p == POS_DST_IP_END) begin
          if (dst_ip_on && !dst_hit(cap.addr_pair[31:0]))
            conclude(ST_DST_IP);
          else if (cap.frag_offset != '0)
            conclude(ST_FRAGMENT);
          else if (cap.protocol != PROTO_TCP && cap.protocol != PROTO_UDP)
            conclude(ST_OTHER_PROTO);
          else if (cap.ver_ihl[3:0] < MIN_IHL)
            conclude(ST_BAD_IHL);
        end
      end else if (p >= POS_ADDR_END) begin
        // transport header starts after the IP options
        l4 = int'(ETH_HDR_LEN) + 4 * int'(cap.ver_ihl[3:0]);
        if (p >= l4) begin
          off = p - l4;
          if (off < OFF_PORTS_END) begin
            cap.port_pair = {cap.port_pair[23:0], b};
            if (off == OFF_SPORT_LO && sport_want != '0 && cap.port_pair[15:0] != sport_want)
              conclude(ST_SPORT);
            else if (off == OFF_DPORT_LO && dport_want != '0 &&
                     cap.port_pair[15:0] != dport_want)
              conclude(ST_DPORT);
          end else if (cap.protocol == PROTO_UDP) begin
            if (off < OFF_UDP_END) begin
              cap.transport = {cap.transport[7:0], b};
              if (off == OFF_UDP_LEN_LO)
                conclude(ST_UDP_OK);
            end
          end else if (off == OFF_TCP_FLAGS) begin
            cap.transport = {14'd0, b[1:0]};
            conclude(ST_TCP_OK);
          end
        end
      end
    endfunction

    // Called for every accepted byte transfer
    function void note_byte(logic [7:0] b, logic last);
      header_result_t r;
      if (!verdict_set)
        absorb(int'(frame_pos), b);
      if (frame_pos != POS_MAX)
        frame_pos++;
      if (last) begin
        r        = cap;
        r.status = verdict_set ? verdict : ST_TRUNCATED;
        verdicts_owed.push_back(r);
        clear_frame();
      end
    endfunction

    task report_mismatch(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic [63:0] got_v, logic [63:0] want_v);
      if (got_v !== want_v)
        report_mismatch($sformatf("verdict %0d %s: got %0h, expected %0h",
                                  checked, name, got_v, want_v));
    endtask

    task check_result(header_result_t got);
      header_result_t want;
      if (verdicts_owed.size() == 0) begin
        report_mismatch("result transfer with no frame outstanding");
        return;
      end
      want = verdicts_owed.pop_front();
      checked++;
      seen[want.status]++;
      compare_field("status", 64'(got.status), 64'(want.status));
      compare_field("dst_mac", 64'(got.dst_mac), 64'(want.dst_mac));
      compare_field("src_mac", 64'(got.src_mac), 64'(want.src_mac));
      compare_field("ethertype", 64'(got.ethertype), 64'(want.ethertype));
      compare_field("ip_version_ihl", 64'(got.ver_ihl), 64'(want.ver_ihl));
      compare_field("ip_total_length", 64'(got.total_length), 64'(want.total_length));
      compare_field("fragment_offset", 64'(got.frag_offset), 64'(want.frag_offset));
      compare_field("time_to_live", 64'(got.ttl), 64'(want.ttl));
      compare_field("proto_number", 64'(got.protocol), 64'(want.protocol));
      compare_field("ip_address_pair", got.addr_pair, want.addr_pair);
      compare_field("port_pair", 64'(got.port_pair), 64'(want.port_pair));
      compare_field("transport_info", 64'(got.transport), 64'(want.transport));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          in_data_byte;
  logic                in_last_byte;
  logic                out_valid;
  logic                out_ready;
  logic [3:0]          out_status;
  logic [47:0]         out_dst_mac;
  logic [47:0]         out_src_mac;
  logic [15:0]         out_ethertype;
  logic [7:0]          out_ip_version_ihl;
  logic [15:0]         out_ip_total_length;
  logic [12:0]         out_fragment_offset;
  logic [7:0]          out_time_to_live;
  logic [7:0]          out_proto_number;
  logic [63:0]         out_ip_address_pair;
  logic [31:0]         out_port_pair;
  logic [15:0]         out_transport_info;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  header_scoreboard sb = new();

  logic [7:0] frame_q[$];
  bit         tx_steady = 1'b0;
  bit         rx_steady = 1'b0;
  int         hold_requests = 0;
  int         items_sent = 0;
  int         frames_sent = 0;
  int         settings_used = 0;

  eth_ipv4_l4_header_parse_filter DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_dst_mac         (out_dst_mac),
    .out_src_mac         (out_src_mac),
    .out_ethertype       (out_ethertype),
    .out_ip_version_ihl  (out_ip_version_ihl),
    .out_ip_total_length (out_ip_total_length),
    .out_fragment_offset (out_fragment_offset),
    .out_time_to_live    (out_time_to_live),
    .out_proto_number    (out_proto_number),
    .out_ip_address_pair (out_ip_address_pair),
    .out_port_pair       (out_port_pair),
    .out_transport_info  (out_transport_info),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // 12-unit clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #(12 * 1_000_000);
    $display("Timed out with %0d verdicts outstanding", sb.pending());
    $display("== FAIL ==");
    $finish;
  end

  // Result side: random stalls, plus long hold-offs on request
  initial begin : result_sink
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (holds_done < hold_requests) begin
        holds_done++;
        hold_left = 250;
        out_ready <= 1'b0;
      end else begin
        out_ready <= rx_steady || ($urandom_range(99) >= 26);
      end
    end
  end

  // Result transfers go straight to the scoreboard
  always @(posedge clk) begin : result_monitor
    header_result_t got;
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      got.status       = status_t'(out_status);
      got.dst_mac      = out_dst_mac;
      got.src_mac      = out_src_mac;
      got.ethertype    = out_ethertype;
      got.ver_ihl      = out_ip_version_ihl;
      got.total_length = out_ip_total_length;
      got.frag_offset  = out_fragment_offset;
      got.ttl          = out_time_to_live;
      got.protocol     = out_proto_number;
      got.addr_pair    = out_ip_address_pair;
      got.port_pair    = out_port_pair;
      got.transport    = out_transport_info;
      sb.check_result(got);
    end
  end

  function automatic bit tx_gap();
    return !tx_steady && ($urandom_range(99) < 26);
  endfunction

  // Register write: setup then access; starts and ends on a falling edge
  task automatic apb_write(reg_idx_t idx, logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.write_reg(idx, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_filters(logic [31:0] sip, logic sip_on, logic [31:0] dip,
                                 logic dip_on, logic [15:0] sp, logic [15:0] dp);
    apb_write(REG_SRC_IP_MATCH, sip);
    apb_write(REG_SRC_IP_ON, {31'd0, sip_on});
    apb_write(REG_DST_IP_MATCH, dip);
    apb_write(REG_DST_IP_ON, {31'd0, dip_on});
    apb_write(REG_SRC_PORT, {16'd0, sp});
    apb_write(REG_DST_PORT, {16'd0, dp});
    settings_used++;
  endtask

  // One byte transfer; called and returns on a falling edge
  task automatic send_byte(logic [7:0] b, logic last);
    while (tx_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_byte(b, last);
    items_sent++;
    @(negedge clk);
  endtask

  // Send the built frame, cut short to 'cut' bytes when cut is positive
  task automatic send_frame(int cut);
    int n;
    n = (cut > 0 && cut < frame_q.size()) ? cut : frame_q.size();
    for (int i = 0; i < n; i++)
      send_byte(frame_q[i], i == n - 1);
    frames_sent++;
  endtask

  // Sender pauses until every verdict is back, then lets the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic void put_bytes(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--)
      frame_q.push_back(v[8*i +: 8]);
  endfunction

  // Ethernet + IPv4 header (+ options) + ports + 'tail' transport bytes
  function automatic void assemble_frame(logic [15:0] etype, logic [7:0] vih,
                                         logic [15:0] frag, logic [7:0] proto,
                                         logic [31:0] sip, logic [31:0] dip,
                                         logic [15:0] sp, logic [15:0] dp, int tail);
    frame_q.delete();
    put_bytes({$urandom, $urandom}, 6);
    put_bytes({$urandom, $urandom}, 6);
    put_bytes(64'(etype), 2);
    put_bytes(64'(vih), 1);
    put_bytes(64'($urandom), 5);      // TOS, total length, identification
    put_bytes(64'(frag), 2);
    put_bytes(64'($urandom), 1);      // TTL
    put_bytes(64'(proto), 1);
    put_bytes(64'($urandom), 2);      // header checksum
    put_bytes(64'(sip), 4);
    put_bytes(64'(dip), 4);
    for (int k = 20; k < 4 * vih[3:0]; k++)
      put_bytes(64'($urandom), 1);
    put_bytes(64'(sp), 2);
    put_bytes(64'(dp), 2);
    repeat (tail) put_bytes(64'($urandom), 1);
  endfunction

  // Mostly well-formed frames aimed at the current filters, plus broken ones
  task automatic random_frame();
    int          pick;
    int          cut;
    int          tail;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [15:0] frag;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [7:0]  vih;
    pick  = $urandom_range(99);
    cut   = 0;
    etype = ETHERTYPE_IPV4;
    sip   = ($urandom_range(99) < 80) ? sb.src_ip_want : $urandom;
    dip   = $urandom;
    if ($urandom_range(99) < 80)
      for (int k = 0; k < 4; k++)
        if (sb.dst_ip_want[8*k +: 8] != 8'd0)
          dip[8*k +: 8] = sb.dst_ip_want[8*k +: 8];
    sp    = ($urandom_range(99) < 80 && sb.sport_want != '0) ? sb.sport_want
                                                              : 16'($urandom);
    dp    = ($urandom_range(99) < 80 && sb.dport_want != '0) ? sb.dport_want
                                                              : 16'($urandom);
    proto = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
    vih   = {($urandom_range(99) < 90) ? 4'h4 : 4'($urandom),
             ($urandom_range(99) < 80) ? 4'd5 : 4'($urandom_range(15, 6))};
    frag  = {3'($urandom), ($urandom_range(99) < 88) ? 13'd0 : 13'($urandom_range(8191, 1))};
    tail  = (proto == PROTO_UDP) ? $urandom_range(12, 1) : $urandom_range(24, 8);
    if (pick < 60) begin
      if ($urandom_range(99) < 15)
        cut = -1;
    end else if (pick < 72) begin
      // short non-IPv4 frames
      etype = 16'($urandom);
      if (etype == ETHERTYPE_IPV4)
        etype = 16'h86DD;
      cut = $urandom_range(40, 1);
    end else if (pick < 86) begin
      case ($urandom_range(2))
        0: do proto = 8'($urandom); while (proto == PROTO_TCP || proto == PROTO_UDP);
        1: vih[3:0] = 4'($urandom_range(4));
        default: frag[12:0] = 13'($urandom_range(8191, 1));
      endcase
    end
    if (pick >= 86) begin
      frame_q.delete();
      repeat ($urandom_range(48, 1)) frame_q.push_back(8'($urandom));
    end else begin
      assemble_frame(etype, vih, frag, proto, sip, dip, sp, dp, tail);
    end
    if (cut < 0)
      cut = $urandom_range(frame_q.size() - 1, 1);
    send_frame(cut);
  endtask

  task automatic run_random_phase(int byte_goal, int frame_goal, bit with_hold);
    int items0;
    int frames0;
    items0  = items_sent;
    frames0 = frames_sent;
    while (items_sent - items0 < byte_goal || frames_sent - frames0 < frame_goal) begin
      // receiver holds off while frames keep coming, so the block backs up
      if (with_hold && frames_sent - frames0 == 3)
        hold_requests++;
      random_frame();
      if ($urandom_range(99) < 4)
        wait_drained();
    end
  endtask

  // Directed frames under a mid-range filter setting
  task automatic run_directed();
    logic [31:0] sip;
    logic [31:0] dip;
    sip = 32'h0A00_0001;
    dip = 32'hC0A8_0102;
    assemble_frame(ETHERTYPE_IPV4, 8'h45, 16'h4000, PROTO_TCP, sip, dip, 16'h1234,
                   16'h0050, 20);
    send_frame(0);
    assemble_frame(ETHERTYPE_IPV4, 8'h45, 16'h0000, PROTO_UDP, sip, dip, 16'h1234,
                   16'h0050, 8);
    send_frame(0);
    // non-IPv4: trailing bytes after the verdict are ignored
    assemble_frame(16'h86DD, 8'h45, 16'h0000, PROTO_TCP, sip, dip, 16'h1234, 16'h0050, 10);
    send_frame(0);
    // verdict reached on the last byte
    send_frame(14);
    assemble_frame(ETHERTYPE_IPV4, 8'h45, 16'h0000, PROTO_TCP, 32'h0A00_0002, dip,
                   16'h1234, 16'h0050, 20);
    send_frame(0);
    assemble_frame(ETHERTYPE_IPV4, 8'h45, 16'h0000, PROTO_TCP, sip, 32'hC0A9_0102,
                   16'h1234, 16'h0050, 20);
    send_frame(0);
    assemble_frame(ETHERTYPE_IPV4, 8'h45, 16'h2001, PROTO_TCP, sip, dip, 16'h1234,
                   16'h0050, 20);
    send_frame(0);
    assemble_frame(ETHERTYPE_IPV4, 8'h45, 16'h0000, 8'd1, sip, dip, 16'h1234, 16'h0050, 20);
    send_frame(0);
    // header length below the minimum, including zero
    assemble_frame(ETHERTYPE_IPV4, 8'h44, 16'h0000, PROTO_TCP, sip, dip, 16'h1234,
                   16'h0050, 20);
    send_frame(0);
    assemble_frame(ETHERTYPE_IPV4, 8'h40, 16'h0000, PROTO_UDP, sip, dip, 16'h1234,
                   16'h0050, 20);
    send_frame(0);
    assemble_frame(ETHERTYPE_IPV4, 8'h45, 16'h0000, PROTO_TCP, sip, dip, 16'h1235,
                   16'h0050, 20);
    send_frame(0);
    assemble_frame(ETHERTYPE_IPV4, 8'h45, 16'h0000, PROTO_UDP, sip, dip, 16'h1234,
                   16'h0051, 20);
    send_frame(0);
    // truncated in the middle of the IP header
    send_frame(20);
    // UDP ending on the last length byte; TCP ending on the flags byte
    assemble_frame(ETHERTYPE_IPV4, 8'h45, 16'h0000, PROTO_UDP, sip, dip, 16'h1234,
                   16'h0050, 2);
    send_frame(0);
    assemble_frame(ETHERTYPE_IPV4, 8'h45, 16'h0000, PROTO_TCP, sip, dip, 16'h1234,
                   16'h0050, 10);
    send_frame(0);
    // longest header with options
    assemble_frame(ETHERTYPE_IPV4, 8'h4F, 16'h0000, PROTO_TCP, sip, dip, 16'h1234,
                   16'h0050, 14);
    send_frame(0);
    frame_q = {8'hFF};
    send_frame(0);
    frame_q.delete();
    repeat (20) frame_q.push_back(8'h00);
    send_frame(0);
    frame_q.delete();
    repeat (20) frame_q.push_back(8'hFF);
    send_frame(0);
    // bytes well past the verdict are ignored, next frame must start clean
    assemble_frame(ETHERTYPE_IPV4, 8'h45, 16'h0000, PROTO_TCP, sip, dip, 16'h1234,
                   16'h0050, 30);
    send_frame(0);
    assemble_frame(ETHERTYPE_IPV4, 8'h45, 16'h0000, PROTO_UDP, sip, dip, 16'h1234,
                   16'h0050, 6);
    send_frame(0);
  endtask

  // Main sequence
  initial begin : stimulus
    string   tally;
    status_t st;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    sb.reset_model();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    program_filters(32'h0A00_0001, 1'b1, 32'hC0A8_0000, 1'b1, 16'h1234, 16'h0050);
    run_directed();
    run_random_phase(40, 5, 1'b1);

    wait_drained();
    program_filters('0, 1'b0, '0, 1'b0, '0, '0);
    run_random_phase(20, 1, 1'b0);

    // all-ones filters, run with no idling on either side
    wait_drained();
    program_filters('1, 1'b1, '1, 1'b1, '1, '1);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_random_phase(100, 2, 1'b0);
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    wait_drained();
    program_filters('0, 1'b1, '0, 1'b1, 16'h0001, '0);
    run_random_phase(20, 1, 1'b0);

    wait_drained();
    program_filters($urandom, 1'($urandom), $urandom & 32'hFF00_FFFF, 1'($urandom),
                    16'($urandom), 16'($urandom));
    run_random_phase(20, 1, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);

    tally = "";
    for (int k = 0; k <= ST_BAD_IHL; k++) begin
      st    = status_t'(k);
      tally = {tally, $sformatf(" %s:%0d", st.name(), sb.seen[k])};
    end
    $display("Sent %0d frames (%0d bytes) over %0d filter settings, %0d verdicts checked",
             frames_sent, items_sent, settings_used, sb.checked);
    $display("Verdicts:%s", tally);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
